// File: rtl/srsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and codes of the selective-repeat sender window
// Request and result codes, default sizing, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int MAX_WINDOW_DEF = 16;
	localparam int WS_W           = 5;
	localparam int SEQ_W          = 32;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 3;

	localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 5'd16;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_ACK   = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] KIND_SEND   = 2'd0;
	localparam logic [1:0] KIND_RESEND = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic REG_WINDOW_SIZE = 1'b0;

	typedef struct packed {
		logic capture;
		logic start_load;
		logic end_zero;
		logic ack_mark;
		logic slide_step;
		logic end_total;
		logic load_rem;
		logic issue_one;
		logic scan_init;
		logic rd_scan;
		logic tick_found;
		logic scan_adv;
		logic emit_pend_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       tot_zero;
		logic       in_win;
		logic       base_lt_next;
		logic       base_ge_total;
		logic       rd_bit;
		logic       rem_zero;
		logic       rem_one;
		logic       win_empty;
		logic       cnt_one;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/srsw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_dp: sender window datapath
// Sequence counters, ack flag memory, scan counters and the result register.
// ----------------------------------------------------------------------------
module srsw_dp #(
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  srsw_pkg::cmd_t                 cmd,
	output srsw_pkg::status_t              st,
	input  wire [srsw_pkg::WS_W-1:0]       window_size,
	input  wire [1:0]                      mode,
	input  wire [srsw_pkg::SEQ_W-1:0]      seq_in,
	input  wire [srsw_pkg::SEQ_W-1:0]      packet_total,
	output logic                           strobe,
	output logic [1:0]                     kind,
	output logic [srsw_pkg::SEQ_W-1:0]     seq_out,
	output logic                           last
);
	import srsw_pkg::*;

	localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam logic [SW:0]   SLOT_MAX  = (SW + 1)'(MAX_WINDOW);
	localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_WINDOW - 1);
	localparam logic [CW-1:0] WIN_MAX   = CW'(MAX_WINDOW);

	logic [1:0]       mode_q;
	logic [SEQ_W-1:0] seq_q;
	logic [SEQ_W-1:0] tot_q;
	logic [SEQ_W-1:0] base_q;
	logic [SEQ_W-1:0] next_q;
	logic [SEQ_W-1:0] total_q;
	logic [SW-1:0]    base_slot_q;
	logic [SW-1:0]    next_slot_q;
	logic [CW-1:0]    rem_q;
	logic [SEQ_W-1:0] scan_seq_q;
	logic [SW-1:0]    scan_slot_q;
	logic [CW-1:0]    cnt_q;
	logic [SEQ_W-1:0] pend_q;
	logic             have_pend_q;
	logic             rd_q;
	logic             ack_mem [MAX_WINDOW];

	logic             strobe_q;
	logic [1:0]       kind_q;
	logic [SEQ_W-1:0] seq_out_q;
	logic             last_q;

	logic [SEQ_W-1:0] ack_dist;
	logic [SW:0]      ack_sum;
	logic [SW-1:0]    ack_slot;
	logic [CW-1:0]    eff;
	logic [SEQ_W-1:0] outstanding;
	logic [SEQ_W-1:0] tot_gap;
	logic [CW-1:0]    gap_win;
	logic [CW-1:0]    gap_tot;
	logic [CW-1:0]    rem_new;
	logic [SW-1:0]    rd_addr;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		if (s == SLOT_LAST) begin
			return '0;
		end
		return s + SW'(1);
	endfunction

	// slot of an ack: offset from the base slot, wrapped once
	always_comb begin
		ack_dist = seq_q - base_q;
		ack_sum  = {1'b0, base_slot_q} + ack_dist[SW:0];
		if (ack_sum >= SLOT_MAX) begin
			ack_slot = SW'(ack_sum - SLOT_MAX);
		end else begin
			ack_slot = ack_sum[SW-1:0];
		end
	end

	// clamp window size to 1..MAX_WINDOW
	always_comb begin
		if (window_size == '0) begin
			eff = CW'(1);
		end else if ({3'b000, window_size} > 8'(MAX_WINDOW)) begin
			eff = WIN_MAX;
		end else begin
			eff = CW'(window_size);
		end
	end

	// number of new sequences allowed now
	always_comb begin
		outstanding = next_q - base_q;
		tot_gap     = total_q - next_q;
		if (eff > outstanding[CW-1:0]) begin
			gap_win = eff - outstanding[CW-1:0];
		end else begin
			gap_win = '0;
		end
		if (tot_gap > SEQ_W'(MAX_WINDOW)) begin
			gap_tot = WIN_MAX;
		end else begin
			gap_tot = tot_gap[CW-1:0];
		end
		rem_new = (gap_win < gap_tot) ? gap_win : gap_tot;
	end

	assign rd_addr = cmd.rd_scan ? scan_slot_q : base_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.ack_mark) begin
			ack_mem[ack_slot] <= 1'b1;
		end else if (cmd.slide_step) begin
			ack_mem[base_slot_q] <= 1'b0;
		end else if (cmd.issue_one) begin
			ack_mem[next_slot_q] <= 1'b0;
		end
		rd_q <= ack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			seq_q  <= seq_in;
			tot_q  <= packet_total;
		end
		if (cmd.load_rem) begin
			rem_q <= rem_new;
		end else if (cmd.issue_one) begin
			rem_q <= rem_q - CW'(1);
		end
		if (cmd.scan_init) begin
			scan_seq_q  <= base_q;
			scan_slot_q <= base_slot_q;
			cnt_q       <= outstanding[CW-1:0];
		end else if (cmd.scan_adv) begin
			scan_seq_q  <= scan_seq_q + SEQ_W'(1);
			scan_slot_q <= slot_inc(scan_slot_q);
			cnt_q       <= cnt_q - CW'(1);
		end
		if (cmd.tick_found) begin
			pend_q <= scan_seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			total_q     <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			have_pend_q <= 1'b0;
		end else begin
			if (cmd.start_load) begin
				base_q      <= '0;
				next_q      <= '0;
				total_q     <= tot_q;
				base_slot_q <= '0;
				next_slot_q <= '0;
			end else begin
				if (cmd.slide_step) begin
					base_q      <= base_q + SEQ_W'(1);
					base_slot_q <= slot_inc(base_slot_q);
				end
				if (cmd.issue_one) begin
					next_q      <= next_q + SEQ_W'(1);
					next_slot_q <= slot_inc(next_slot_q);
				end
			end
			if (cmd.scan_init) begin
				have_pend_q <= 1'b0;
			end else if (cmd.tick_found) begin
				have_pend_q <= 1'b1;
			end
		end
	end

	// result register: one result per cycle at most
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.end_zero | cmd.end_total | cmd.issue_one |
				(cmd.tick_found & have_pend_q) | cmd.emit_pend_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_zero) begin
			kind_q    <= KIND_END;
			seq_out_q <= '0;
			last_q    <= 1'b1;
		end else if (cmd.end_total) begin
			kind_q    <= KIND_END;
			seq_out_q <= total_q;
			last_q    <= 1'b1;
		end else if (cmd.issue_one) begin
			kind_q    <= KIND_SEND;
			seq_out_q <= next_q;
			last_q    <= (rem_q == CW'(1));
		end else if (cmd.tick_found || cmd.emit_pend_last) begin
			kind_q    <= KIND_RESEND;
			seq_out_q <= pend_q;
			last_q    <= cmd.emit_pend_last;
		end
	end

	assign strobe  = strobe_q;
	assign kind    = kind_q;
	assign seq_out = seq_out_q;
	assign last    = last_q;

	always_comb begin
		st.mode          = mode_q;
		st.tot_zero      = (tot_q == '0);
		st.in_win        = (seq_q >= base_q) && (seq_q < next_q);
		st.base_lt_next  = (base_q < next_q);
		st.base_ge_total = (base_q >= total_q);
		st.rd_bit        = rd_q;
		st.rem_zero      = (rem_q == '0);
		st.rem_one       = (rem_q == CW'(1));
		st.win_empty     = (next_q == base_q);
		st.cnt_one       = (cnt_q == CW'(1));
	end

endmodule
`default_nettype wire

// File: rtl/srsw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_ctrl: sender window controller
// Sequences decode, base slide, new issue and resend scan of one request.
// ----------------------------------------------------------------------------
module srsw_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  srsw_pkg::status_t  st,
	output srsw_pkg::cmd_t     cmd
);
	import srsw_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SL_RD  = 4'd2;
	localparam logic [3:0] S_SL_CHK = 4'd3;
	localparam logic [3:0] S_PREP   = 4'd4;
	localparam logic [3:0] S_ISSUE  = 4'd5;
	localparam logic [3:0] S_TK_RD  = 4'd6;
	localparam logic [3:0] S_TK_CHK = 4'd7;
	localparam logic [3:0] S_TK_FIN = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       active_q;
	logic       active_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		active_d = active_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (st.mode)
					MODE_START: begin
						cmd.start_load = 1'b1;
						if (st.tot_zero) begin
							cmd.end_zero = 1'b1;
							active_d     = 1'b0;
						end else begin
							active_d = 1'b1;
							state_d  = S_PREP;
						end
					end
					MODE_ACK: begin
						if (active_q && st.in_win) begin
							cmd.ack_mark = 1'b1;
							state_d      = S_SL_RD;
						end
					end
					MODE_TICK: begin
						if (active_q && !st.win_empty) begin
							cmd.scan_init = 1'b1;
							state_d       = S_TK_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SL_RD: begin
				state_d = S_SL_CHK;
			end
			S_SL_CHK: begin
				if (st.base_lt_next && st.rd_bit) begin
					cmd.slide_step = 1'b1;
					state_d        = S_SL_RD;
				end else if (st.base_ge_total) begin
					cmd.end_total = 1'b1;
					active_d      = 1'b0;
					state_d       = S_IDLE;
				end else begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.load_rem = 1'b1;
				state_d      = S_ISSUE;
			end
			S_ISSUE: begin
				if (st.rem_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.issue_one = 1'b1;
					if (st.rem_one) begin
						state_d = S_IDLE;
					end
				end
			end
			S_TK_RD: begin
				cmd.rd_scan = 1'b1;
				state_d     = S_TK_CHK;
			end
			S_TK_CHK: begin
				cmd.tick_found = !st.rd_bit;
				cmd.scan_adv   = 1'b1;
				state_d        = st.cnt_one ? S_TK_FIN : S_TK_RD;
			end
			S_TK_FIN: begin
				cmd.emit_pend_last = 1'b1;
				state_d            = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/selective_repeat_sender_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender side of a selective-repeat window
// Issues, acknowledges and resends sequence numbers within a sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive mode, seq_in and packet_total and raise start; the
//   request is taken at a clock edge where start is high and busy is low.
//   Mode start loads the packet count and sends the first window; ack marks a
//   sequence and slides the base; tick resends every unacked sequence.
//   Result channel: each result shows on kind, seq_out and last for exactly
//   one cycle with strobe high; last marks the final result of a request.
//   The receiver cannot stall, so results are never held back.
//   Sequencing: busy holds through a decode state; a start then issues new
//   sends; an ack slides the base one entry at a time, then issues new sends
//   unless it ends the transfer; a tick scans every window entry. The ack flag
//   memory read is registered, so each slide or scan step has a read and a check state.
//   window_size is written through the APB port at byte address 0; the user
//   must write it only while idle, since the block does not enforce this.
//   Reset clears the window, leaves the block idle and sets window_size to 16.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// request channel
	input  wire                              start,
	output logic                             busy,
	input  wire [1:0]                        mode,
	input  wire [srsw_pkg::SEQ_W-1:0]        seq_in,
	input  wire [srsw_pkg::SEQ_W-1:0]        packet_total,
	// result channel
	output logic                             strobe,
	output logic [1:0]                       kind,
	output logic [srsw_pkg::SEQ_W-1:0]       seq_out,
	output logic                             last,
	// configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [srsw_pkg::ADDR_W-1:0]       paddr,
	input  wire [srsw_pkg::DATA_W-1:0]       pwdata,
	output logic [srsw_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import srsw_pkg::*;

	logic [WS_W-1:0] window_size_q;
	logic            cfg_wr;
	cmd_t            cmd;
	status_t         st;

	// Register file: one register, decoded on the word address bit.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_wr && (paddr[2] == REG_WINDOW_SIZE)) begin
			window_size_q <= pwdata[WS_W-1:0];
		end
	end

	// Read back the window size; unused addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_SIZE) begin
			prdata = {{(DATA_W - WS_W){1'b0}}, window_size_q};
		end
	end

	// Controller: steps one request through decode, slide, issue or scan.
	srsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// Datapath: counters, ack flags and the result register.
	srsw_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.window_size  (window_size_q),
		.mode         (mode),
		.seq_in       (seq_in),
		.packet_total (packet_total),
		.strobe       (strobe),
		.kind         (kind),
		.seq_out      (seq_out),
		.last         (last)
	);

`ifndef SYNTHESIS
	// A result only follows a cycle of request processing.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without a request in progress");

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// An end marker is always the final result of its request.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (kind == KIND_END)) |-> last)
		else $error("end marker without last");
`endif

endmodule
`default_nettype wire
